// ----- rtl/core/xor_checked_command_framer_defines.svh -----
// Assertion macros shared by the framer RTL.
`ifndef XOR_CHECKED_COMMAND_FRAMER_DEFINES_SVH
`define XOR_CHECKED_COMMAND_FRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle check: whenever cond holds, prop holds too.
`define XCF_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle check: whenever cond holds, prop holds in the following cycle.
`define XCF_ASSERT_NEXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define XCF_ASSERT_IMP(label, cond, prop, msg)
`define XCF_ASSERT_NEXT(label, cond, prop, msg)
`endif
`endif

// ----- rtl/core/xcf_pkg.sv -----
package xcf_pkg;

  localparam logic [7:0] SYNC_BYTE      = 8'h02;
  localparam logic [7:0] ADDR_HIGH_BYTE = 8'h00;
  localparam logic [7:0] ADDR_MIN       = 8'd1;
  localparam logic [7:0] ADDR_MAX       = 8'd32;
  localparam logic [4:0] FRAME_OVERHEAD = 5'd5;
  localparam logic [7:0] CAPACITY_RESET = 8'd27;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  // Register index taken from paddr[2].
  localparam logic REG_CAPACITY = 1'b0;

  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [1:0] {
    JOB_REJECT,
    JOB_HEADER,
    JOB_DATA
  } job_op_t;

  // One classified item: what the back end has to put on the wire.
  typedef struct packed {
    job_op_t    op;
    logic [7:0] lead;    // slave address for a header or a reject, data byte for data
    logic [7:0] cmd;
    logic       close;   // check byte follows
    logic [7:0] check;
    logic [4:0] flen;
  } job_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } queue_status_t;

endpackage

// ----- rtl/core/xcf_ifs.sv -----
interface xcf_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] slave_address;
  logic [7:0] command;
  logic [7:0] payload_length;
  logic [7:0] payload_byte;

  modport source (output valid, kind, slave_address, command, payload_length, payload_byte,
                  input ready);
  modport sink (input valid, kind, slave_address, command, payload_length, payload_byte,
                output ready);
endinterface

interface xcf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last;
  logic       rejected;
  logic [4:0] frame_length;

  modport source (output valid, frame_byte, last, rejected, frame_length, input ready);
  modport sink (input valid, frame_byte, last, rejected, frame_length, output ready);
endinterface

// ----- rtl/core/xcf_front.sv -----
module xcf_front #(
  parameter int MAX_PAYLOAD = 22
) (
  input  logic                   clk,
  input  logic                   rst,
  xcf_in_if.sink                 items,
  input  logic [7:0]             capacity,
  input  xcf_pkg::queue_status_t q_status,
  output logic                   push,
  output xcf_pkg::job_t          push_job
);
  import xcf_pkg::*;

  localparam int CW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]    running_xor, running_xor_next;
  logic [CW-1:0] bytes_remaining, bytes_remaining_next;
  logic [CW-1:0] payload_count, payload_count_next;
  logic          frame_open, frame_open_next;

  logic          accept;
  logic          start_bad;
  logic [8:0]    frame_need;
  logic [7:0]    hdr_xor;
  logic [7:0]    data_xor;
  logic [CW-1:0] count_inc;
  logic [8:0]    data_flen;

  assign items.ready = !q_status.full;
  assign accept      = items.valid && items.ready;

  assign frame_need = {4'b0, FRAME_OVERHEAD} + {1'b0, items.payload_length};
  assign start_bad  = frame_open
                   || (items.slave_address < ADDR_MIN)
                   || (items.slave_address > ADDR_MAX)
                   || ({1'b0, items.payload_length} > 9'(MAX_PAYLOAD))
                   || (frame_need > {1'b0, capacity});
  assign hdr_xor    = ADDR_HIGH_BYTE ^ items.slave_address ^ items.command;
  assign data_xor   = running_xor ^ items.payload_byte;
  assign count_inc  = payload_count + CW'(1);
  assign data_flen  = {4'b0, FRAME_OVERHEAD} + 9'(count_inc);

  always_comb begin
    running_xor_next     = running_xor;
    bytes_remaining_next = bytes_remaining;
    payload_count_next   = payload_count;
    frame_open_next      = frame_open;
    push                 = accept;
    push_job.op          = JOB_REJECT;
    push_job.lead        = items.slave_address;
    push_job.cmd         = items.command;
    push_job.close       = 1'b0;
    push_job.check       = 8'h00;
    push_job.flen        = 5'd0;
    if (accept) begin
      if (items.kind == KIND_START) begin
        if (!start_bad) begin
          push_job.op = JOB_HEADER;
          if (items.payload_length == 8'd0) begin
            // empty frame: header and check byte in one run, frame stays closed
            push_job.close = 1'b1;
            push_job.check = hdr_xor;
            push_job.flen  = FRAME_OVERHEAD;
          end else begin
            frame_open_next      = 1'b1;
            running_xor_next     = hdr_xor;
            bytes_remaining_next = items.payload_length[CW-1:0];
            payload_count_next   = '0;
          end
        end
      end else if (frame_open) begin
        push_job.op   = JOB_DATA;
        push_job.lead = items.payload_byte;
        if (bytes_remaining == CW'(1)) begin
          push_job.close       = 1'b1;
          push_job.check       = data_xor;
          push_job.flen        = data_flen[4:0];
          frame_open_next      = 1'b0;
          running_xor_next     = 8'h00;
          bytes_remaining_next = '0;
          payload_count_next   = '0;
        end else begin
          running_xor_next     = data_xor;
          bytes_remaining_next = bytes_remaining - CW'(1);
          payload_count_next   = count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_xor     <= 8'h00;
      bytes_remaining <= '0;
      payload_count   <= '0;
      frame_open      <= 1'b0;
    end else begin
      running_xor     <= running_xor_next;
      bytes_remaining <= bytes_remaining_next;
      payload_count   <= payload_count_next;
      frame_open      <= frame_open_next;
    end
  end

endmodule

// ----- rtl/core/xcf_queue.sv -----
`include "xor_checked_command_framer_defines.svh"
module xcf_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  xcf_pkg::job_t          push_job,
  input  logic                   pop,
  output xcf_pkg::job_t          head,
  output xcf_pkg::queue_status_t status
);
  import xcf_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  job_t        slots [QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [AW:0]   count;
  logic          do_push;
  logic          do_pop;

  assign status.full       = (count == (AW+1)'(QUEUE_DEPTH));
  assign status.head_valid = (count != '0);
  assign head              = slots[rd_ptr];
  assign do_push           = push && !status.full;
  assign do_pop            = pop && status.head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      count <= count + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end

  `XCF_ASSERT_IMP(a_count_bound, 1'b1, count <= (AW+1)'(QUEUE_DEPTH), "queue count overran depth")
  `XCF_ASSERT_NEXT(a_push_counts, do_push && !do_pop, count == $past(count) + (AW+1)'(1),
    "queue count missed a push")
  `XCF_ASSERT_NEXT(a_pop_counts, do_pop && !do_push, count == $past(count) - (AW+1)'(1),
    "queue count missed a pop")

endmodule

// ----- rtl/core/xcf_back.sv -----
`include "xor_checked_command_framer_defines.svh"
module xcf_back (
  input  logic                   clk,
  input  logic                   rst,
  input  xcf_pkg::job_t          head,
  input  xcf_pkg::queue_status_t q_status,
  output logic                   pop,
  xcf_out_if.source              frames
);
  import xcf_pkg::*;

  localparam logic [2:0] STEP_FIRST  = 3'd0;
  localparam logic [2:0] STEP_CHECK  = 3'd1;  // check step of a data run
  localparam logic [2:0] STEP_ADDR   = 3'd2;
  localparam logic [2:0] STEP_CMD    = 3'd3;
  localparam logic [2:0] STEP_HCHECK = 3'd4;  // check step of a header run

  logic [2:0] step;
  logic       load;
  logic       final_step;
  logic [7:0] res_byte;
  logic       res_last;
  logic       res_rej;
  logic [4:0] res_flen;

  assign load = q_status.head_valid && (!frames.valid || frames.ready);
  assign pop  = load && final_step;

  always_comb begin
    res_byte   = 8'h00;
    res_last   = 1'b0;
    res_rej    = 1'b0;
    res_flen   = 5'd0;
    final_step = 1'b0;
    case (head.op)
      JOB_REJECT: begin
        res_last   = 1'b1;
        res_rej    = 1'b1;
        final_step = 1'b1;
      end
      JOB_HEADER: begin
        case (step)
          STEP_FIRST: res_byte = SYNC_BYTE;
          STEP_CHECK: res_byte = ADDR_HIGH_BYTE;
          STEP_ADDR:  res_byte = head.lead;
          STEP_CMD: begin
            res_byte   = head.cmd;
            res_last   = !head.close;
            final_step = !head.close;
          end
          default: begin
            res_byte   = head.check;
            res_last   = 1'b1;
            res_flen   = head.flen;
            final_step = 1'b1;
          end
        endcase
      end
      JOB_DATA: begin
        if (step == STEP_FIRST) begin
          res_byte   = head.lead;
          res_last   = !head.close;
          final_step = !head.close;
        end else begin
          res_byte   = head.check;
          res_last   = 1'b1;
          res_flen   = head.flen;
          final_step = 1'b1;
        end
      end
      default: begin
        res_last   = 1'b1;
        res_rej    = 1'b1;
        final_step = 1'b1;
      end
    endcase
  end

  // Output register: payload loads without reset, valid is control.
  always_ff @(posedge clk) begin
    if (load) begin
      frames.frame_byte   <= res_byte;
      frames.last         <= res_last;
      frames.rejected     <= res_rej;
      frames.frame_length <= res_flen;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames.valid <= 1'b0;
      step         <= STEP_FIRST;
    end else begin
      if (load) begin
        frames.valid <= 1'b1;
      end else if (frames.ready) begin
        frames.valid <= 1'b0;
      end
      if (pop) begin
        step <= STEP_FIRST;
      end else if (load) begin
        step <= step + 3'd1;
      end
    end
  end

  `XCF_ASSERT_IMP(a_reject_shape, frames.valid && frames.rejected,
    frames.last && frames.frame_byte == 8'h00 && frames.frame_length == 5'd0,
    "rejected result carries frame data")
  `XCF_ASSERT_IMP(a_flen_on_last, frames.valid && frames.frame_length != 5'd0, frames.last,
    "frame length shown on a non-final result")
  `XCF_ASSERT_IMP(a_step_idle, !q_status.head_valid, step == STEP_FIRST,
    "run step left over with empty queue")
  `XCF_ASSERT_IMP(a_step_range, 1'b1, step <= STEP_HCHECK, "run step out of range")

endmodule

// ----- rtl/core/xor_checked_command_framer.sv -----
// Channel   Dir  Payload                                                Handshake
// items     in   kind, slave_address, command, payload_length,          valid/ready
//                payload_byte
// frames    out  frame_byte, last, rejected, frame_length                valid/ready
// apb       cfg  capacity register at byte 0 (paddr[2] selects)          psel/penable
//
// Results: one per clock while frames.ready is high; a data item gives one result
// (two when it closes the frame with the check byte), a start item four (five for an
// empty frame) and a refused item one. With the queue empty, an item's first result
// passes the job queue and then the output register on its way to frames.
// Reset: rst synchronous, active high; clears frame state, queue, output valid.
// Stalls: a low frames.ready holds the back end; items.ready drops when the queue fills.
`include "xor_checked_command_framer_defines.svh"
module xor_checked_command_framer #(
  parameter int MAX_PAYLOAD = 22
) (
  input  logic        clk,
  input  logic        rst,
  xcf_in_if.sink      items,
  xcf_out_if.source   frames,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import xcf_pkg::*;

  logic [7:0]    capacity;
  logic          cfg_write;
  logic          push;
  logic          pop;
  job_t          push_job;
  job_t          head;
  queue_status_t q_status;

  // APB: zero wait states; write on the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_CAPACITY) ? {24'b0, capacity} : 32'b0;

  // Capacity comes out of reset at 27.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (cfg_write && paddr[2] == REG_CAPACITY) begin
      capacity <= pwdata[7:0];
    end
  end

  // Front: classify each item, keep the open-frame state, emit one job.
  xcf_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .capacity (capacity),
    .q_status (q_status),
    .push     (push),
    .push_job (push_job)
  );

  // Queue: decouple classification from the byte-by-byte run.
  xcf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .status   (q_status)
  );

  // Back: expand each job into its results, one per cycle while frames.ready allows.
  xcf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_status (q_status),
    .pop      (pop),
    .frames   (frames)
  );

  `XCF_ASSERT_IMP(a_take_needs_room, items.valid && items.ready, !q_status.full,
    "item taken while job queue full")
  `XCF_ASSERT_NEXT(a_cfg_takes, cfg_write && paddr[2] == REG_CAPACITY,
    capacity == $past(pwdata[7:0]), "capacity write lost")
  `XCF_ASSERT_IMP(a_pop_needs_load, pop, q_status.head_valid,
    "job popped from empty queue")

endmodule

// ----- sim/tb_xor_checked_command_framer.sv -----
`timescale 1ns / 1ps

module tb_xor_checked_command_framer;
  import xcf_pkg::*;

  localparam int PAYLOAD_MAX = 22;
  // Cycles with no item, result or register access before the run is given up.
  localparam int WATCHDOG_LIMIT = 1000;
  // Print at most this many mismatch lines; every mismatch is still counted.
  localparam int REPORT_LINES = 50;

  // One input item, as the sender presents it.
  typedef struct packed {
    logic       kind;
    logic [7:0] slave_address;
    logic [7:0] command;
    logic [7:0] payload_length;
    logic [7:0] payload_byte;
  } item_t;

  // One result on the byte stream.
  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       rejected;
    logic [4:0] frame_length;
  } frame_res_t;

  // A row of the directed table: the item and, where it is plain to see,
  // the single result it must give.
  typedef struct packed {
    item_t      it;
    logic       typed;
    frame_res_t want;
  } dir_step_t;

  localparam frame_res_t REFUSED = '{8'h00, 1'b1, 1'b1, 5'd0};
  localparam frame_res_t NO_RES  = '0;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  xcf_in_if  items_bus ();
  xcf_out_if frames_bus ();

  xor_checked_command_framer #(
    .MAX_PAYLOAD(PAYLOAD_MAX)
  ) uut (
    .clk    (clk),
    .rst    (rst),
    .items  (items_bus),
    .frames (frames_bus),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  // Framer state as the testbench sees it.
  logic [7:0] cap_reg;
  logic [7:0] xor_acc;
  logic [4:0] bytes_left;
  logic       in_frame;
  logic [4:0] data_count;

  frame_res_t step_results[$];     // results of the item just accepted
  frame_res_t expected_frames[$];  // results still due on the byte stream
  frame_res_t got_res;
  frame_res_t want_res;

  int  fail_count = 0;
  int  results_checked = 0;
  int  stalled_cycles = 0;
  int  hold_off_len = 0;
  bit  in_idle_on = 1'b1;
  bit  out_stall_on = 1'b1;

  int phase_capacity[6] = '{255, 12, 27, 5, 0, 200};
  int phase_items[6]    = '{100, 70, 90, 50, 30, 126};

  // Directed items: every refusal but the capacity one, both header extremes, an empty frame,
  // a start inside an open frame and a frame that fills the reset capacity.
  dir_step_t dir_steps[14] = '{
    '{'{KIND_DATA,  8'h20, 8'h5A, 8'h03, 8'hA5}, 1'b1, REFUSED},  // data, no frame open
    '{'{KIND_START, 8'h00, 8'h11, 8'h01, 8'h00}, 1'b1, REFUSED},  // address below range
    '{'{KIND_START, 8'h21, 8'h11, 8'h01, 8'h00}, 1'b1, REFUSED},  // address above range
    '{'{KIND_START, 8'hFF, 8'h11, 8'h00, 8'h00}, 1'b1, REFUSED},
    '{'{KIND_START, 8'h01, 8'h11, 8'h17, 8'h00}, 1'b1, REFUSED},  // one byte too long
    '{'{KIND_START, 8'h01, 8'h11, 8'hFF, 8'h00}, 1'b1, REFUSED},
    '{'{KIND_START, 8'h01, 8'h00, 8'h00, 8'hFF}, 1'b0, NO_RES},   // empty frame
    '{'{KIND_START, 8'h20, 8'hFF, 8'h03, 8'h00}, 1'b0, NO_RES},
    '{'{KIND_DATA,  8'hFF, 8'hFF, 8'hFF, 8'h00}, 1'b1, '{8'h00, 1'b1, 1'b0, 5'd0}},
    '{'{KIND_START, 8'h05, 8'h12, 8'h01, 8'h00}, 1'b1, REFUSED},  // start inside a frame
    '{'{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'hFF}, 1'b1, '{8'hFF, 1'b1, 1'b0, 5'd0}},
    '{'{KIND_DATA,  8'h00, 8'h00, 8'h00, 8'h5A}, 1'b0, NO_RES},   // closes the frame
    '{'{KIND_DATA,  8'h7F, 8'h80, 8'h01, 8'h3C}, 1'b1, REFUSED},
    '{'{KIND_START, 8'h01, 8'h3C, 8'h16, 8'h00}, 1'b0, NO_RES}    // fills capacity 27
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string field, input int got, input int want);
    if (fail_count < REPORT_LINES)
      $display("result %0d: %s is %0h, expected %0h", results_checked, field, got, want);
    fail_count++;
  endtask

  function automatic void emit(input logic [7:0] b, input logic l, input logic rj,
                               input logic [4:0] fl);
    frame_res_t r;
    r.frame_byte   = b;
    r.last         = l;
    r.rejected     = rj;
    r.frame_length = fl;
    step_results.push_back(r);
  endfunction

  // Put out the check byte and drop back to idle.
  function automatic void close_frame();
    emit(xor_acc, 1'b1, 1'b0, FRAME_OVERHEAD + data_count);
    in_frame   = 1'b0;
    bytes_left = '0;
    data_count = '0;
    xor_acc    = '0;
  endfunction

  // Work out the results of one accepted item and advance the frame state.
  function automatic void frame_model(input item_t it);
    step_results.delete();
    if (it.kind == KIND_START) begin
      if (in_frame || it.slave_address < ADDR_MIN || it.slave_address > ADDR_MAX ||
          int'(it.payload_length) > PAYLOAD_MAX ||
          int'(it.payload_length) + int'(FRAME_OVERHEAD) > int'(cap_reg)) begin
        emit(8'h00, 1'b1, 1'b1, 5'd0);
      end else begin
        emit(SYNC_BYTE, 1'b0, 1'b0, 5'd0);
        emit(ADDR_HIGH_BYTE, 1'b0, 1'b0, 5'd0);
        emit(it.slave_address, 1'b0, 1'b0, 5'd0);
        // The sync byte stays out of the check byte.
        xor_acc    = ADDR_HIGH_BYTE ^ it.slave_address ^ it.command;
        data_count = '0;
        if (it.payload_length == 8'd0) begin
          emit(it.command, 1'b0, 1'b0, 5'd0);
          close_frame();
        end else begin
          emit(it.command, 1'b1, 1'b0, 5'd0);
          bytes_left = 5'(it.payload_length);
          in_frame   = 1'b1;
        end
      end
    end else if (!in_frame) begin
      emit(8'h00, 1'b1, 1'b1, 5'd0);
    end else begin
      xor_acc    = xor_acc ^ it.payload_byte;
      data_count = data_count + 5'd1;
      bytes_left = bytes_left - 5'd1;
      if (bytes_left == 5'd0) begin
        emit(it.payload_byte, 1'b0, 1'b0, 5'd0);
        close_frame();
      end else begin
        emit(it.payload_byte, 1'b1, 1'b0, 5'd0);
      end
    end
  endfunction

  // Idle length: mostly short, now and then long.
  function automatic int gap_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Pick the next random item from the current frame state: mostly well-formed
  // frames, with stray starts, orphan data and broken headers mixed in.
  function automatic item_t make_random_item();
    item_t it;
    int    room;
    int    lo;
    int    pick;
    it.kind           = KIND_START;
    it.slave_address  = 8'($urandom);
    it.command        = 8'($urandom);
    it.payload_length = 8'($urandom);
    it.payload_byte   = 8'($urandom);
    room = int'(cap_reg) - int'(FRAME_OVERHEAD);
    if (room > PAYLOAD_MAX) room = PAYLOAD_MAX;
    pick = $urandom_range(0, 19);
    if (in_frame) begin
      if (pick == 0) begin
        // Stray start; half of them get an in-range address and a short length.
        if ($urandom_range(0, 1) == 0) begin
          it.slave_address  = 8'($urandom_range(1, 32));
          it.payload_length = 8'($urandom_range(0, 4));
        end
      end else begin
        it.kind = KIND_DATA;
      end
    end else if (pick < 2) begin
      it.kind = KIND_DATA;
    end else if (pick < 5) begin
      case ($urandom_range(0, 3))
        0: it.slave_address = 8'h00;
        1: it.slave_address = 8'($urandom_range(33, 255));
        2: begin
          it.slave_address  = 8'($urandom_range(1, 32));
          it.payload_length = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
        end
        default: begin
          // Just past what capacity allows.
          it.slave_address = 8'($urandom_range(1, 32));
          lo = (room + 1 < 0) ? 0 : room + 1;
          if (lo <= PAYLOAD_MAX)
            it.payload_length = 8'($urandom_range(lo, PAYLOAD_MAX));
          else
            it.payload_length = 8'($urandom_range(PAYLOAD_MAX + 1, 255));
        end
      endcase
    end else begin
      it.slave_address = 8'($urandom_range(1, 32));
      if (room < 0) begin
        it.payload_length = 8'($urandom_range(0, 3));
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6)
          it.payload_length = 8'($urandom_range(0, (room < 4) ? room : 4));
        else if (pick < 8)
          it.payload_length = 8'($urandom_range(0, room));
        else
          it.payload_length = 8'(room);
      end
    end
    return it;
  endfunction

  // Offer one item, hold it until taken, then queue what it must produce.
  // Valid stays high into the next item unless a gap follows.
  task automatic send_item(input item_t it, input bit typed, input frame_res_t want);
    int gap;
    items_bus.valid          <= 1'b1;
    items_bus.kind           <= it.kind;
    items_bus.slave_address  <= it.slave_address;
    items_bus.command        <= it.command;
    items_bus.payload_length <= it.payload_length;
    items_bus.payload_byte   <= it.payload_byte;
    do @(posedge clk); while (!items_bus.ready);
    frame_model(it);
    if (typed)
      expected_frames.push_back(want);
    else
      foreach (step_results[i]) expected_frames.push_back(step_results[i]);
    gap = (in_idle_on && $urandom_range(0, 2) == 0) ? gap_length() : 0;
    if (gap > 0) begin
      items_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Drop valid and wait until every queued result has come out.
  task automatic wait_drained();
    items_bus.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == REG_CAPACITY) cap_reg = data[7:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: take results at random, with random stalls, and hold off for a
  // whole stretch when asked so the framer's job queue fills and stalls input.
  initial begin
    frames_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_len > 0) begin
        frames_bus.ready <= 1'b0;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end else if (out_stall_on && $urandom_range(0, 3) == 0) begin
        frames_bus.ready <= 1'b0;
        repeat (gap_length()) @(posedge clk);
      end else begin
        frames_bus.ready <= 1'b1;
      end
    end
  end

  // Compare every accepted result with the oldest one due, field by field.
  always @(posedge clk) begin
    if (!rst && frames_bus.valid && frames_bus.ready) begin
      got_res.frame_byte   = frames_bus.frame_byte;
      got_res.last         = frames_bus.last;
      got_res.rejected     = frames_bus.rejected;
      got_res.frame_length = frames_bus.frame_length;
      if (expected_frames.size() == 0) begin
        report_mismatch("unexpected result, frame_byte", got_res.frame_byte, 0);
      end else begin
        want_res = expected_frames.pop_front();
        if (got_res.frame_byte !== want_res.frame_byte)
          report_mismatch("frame_byte", got_res.frame_byte, want_res.frame_byte);
        if (got_res.last !== want_res.last)
          report_mismatch("last", got_res.last, want_res.last);
        if (got_res.rejected !== want_res.rejected)
          report_mismatch("rejected", got_res.rejected, want_res.rejected);
        if (got_res.frame_length !== want_res.frame_length)
          report_mismatch("frame_length", got_res.frame_length, want_res.frame_length);
      end
      results_checked++;
    end
  end

  // Watchdog: give up after a long run of cycles in which nothing moves.
  initial begin
    while (stalled_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((items_bus.valid && items_bus.ready) || (frames_bus.valid && frames_bus.ready) ||
          psel)
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("tb_xor_checked_command_framer: FAIL");
    $finish;
  end

  initial begin
    item_t it;
    rst                      <= 1'b1;
    psel                     <= 1'b0;
    penable                  <= 1'b0;
    pwrite                   <= 1'b0;
    paddr                    <= '0;
    pwdata                   <= '0;
    items_bus.valid          <= 1'b0;
    items_bus.kind           <= KIND_START;
    items_bus.slave_address  <= '0;
    items_bus.command        <= '0;
    items_bus.payload_length <= '0;
    items_bus.payload_byte   <= '0;
    cap_reg    = CAPACITY_RESET;
    xor_acc    = '0;
    bytes_left = '0;
    in_frame   = 1'b0;
    data_count = '0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Capacity must read back its reset value before any write.
    apb_read_check({REG_CAPACITY, 2'b00}, 32'(CAPACITY_RESET));

    // Walk the directed table at the reset capacity.
    foreach (dir_steps[i]) send_item(dir_steps[i].it, dir_steps[i].typed, dir_steps[i].want);

    // Random phases, one capacity setting each, extremes among them.
    for (int p = 0; p < 6; p++) begin
      wait_drained();
      apb_write({REG_CAPACITY, 2'b00}, 32'(phase_capacity[p]));
      apb_read_check({REG_CAPACITY, 2'b00}, 32'(phase_capacity[p]));
      for (int n = 0; n < phase_items[p]; n++) begin
        // Reshuffle idling now and then; leave it alone during a hold-off.
        if (n % 16 == 0 && hold_off_len == 0) begin
          in_idle_on   = $urandom_range(0, 2) != 0;
          out_stall_on = $urandom_range(0, 2) != 0;
        end
        // Stall the receiver for a long stretch while items keep coming.
        if (p == 0 && n == 40) begin
          in_idle_on   = 1'b0;
          hold_off_len = 150;
        end
        // Pause the sender until everything queued is out.
        if (p == 2 && n == 60) wait_drained();
        it = make_random_item();
        send_item(it, 1'b0, NO_RES);
      end
    end

    // Let the last results out, then watch for strays.
    items_bus.valid <= 1'b0;
    for (int n = 0; n < 2000 && expected_frames.size() != 0; n++) @(posedge clk);
    repeat (20) @(posedge clk);
    if (expected_frames.size() != 0)
      report_mismatch("results never produced", 0, expected_frames.size());

    if (fail_count == 0)
      $display("tb_xor_checked_command_framer: PASS");
    else
      $display("tb_xor_checked_command_framer: FAIL");
    $finish;
  end

endmodule

// ----- xor_checked_command_framer.f -----
+incdir+rtl/core
rtl/core/xcf_pkg.sv
rtl/core/xcf_ifs.sv
rtl/core/xcf_front.sv
rtl/core/xcf_queue.sv
rtl/core/xcf_back.sv
rtl/core/xor_checked_command_framer.sv
sim/tb_xor_checked_command_framer.sv
